FILE: rtl/core/utf8_decoder_with_rtl_flag_macros.svh
// Assertion macros for the UTF-8 decoder checker.
`ifndef UTF8_DECODER_WITH_RTL_FLAG_MACROS_SVH
`define UTF8_DECODER_WITH_RTL_FLAG_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define UTF8D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that is only checked while a result is on offer.
`define UTF8D_ASSERT_RES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (result_valid && (cond)) |-> (prop)) else $error(msg);

`endif

FILE: rtl/core/utf8d_pkg.sv
// Package: result type, status codes and the right-to-left range check.
`default_nettype none

package utf8d_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_INVALID   = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic [1:0]  byte_count;
        status_t     status;
        logic        right_to_left;
    } result_t;

    localparam logic [15:0] ARABIC_LO   = 16'h0600;
    localparam logic [15:0] ARABIC_HI   = 16'h06FF;
    localparam logic [15:0] ARABIC_S_LO = 16'h0750;
    localparam logic [15:0] ARABIC_S_HI = 16'h077F;
    localparam logic [15:0] ARABIC_A_LO = 16'hFB50;
    localparam logic [15:0] ARABIC_A_HI = 16'hFDFF;
    localparam logic [15:0] ARABIC_B_LO = 16'hFE50;
    localparam logic [15:0] ARABIC_B_HI = 16'hFEFF;
    localparam logic [15:0] HEBREW_LO   = 16'h0590;
    localparam logic [15:0] HEBREW_HI   = 16'h05FF;
    localparam logic [15:0] HEBREW_P_LO = 16'hFB00;
    localparam logic [15:0] HEBREW_P_HI = 16'hFB4F;

    function automatic logic is_rtl(input logic [15:0] c);
        is_rtl = (c >= ARABIC_LO   && c <= ARABIC_HI)   ||
                 (c >= ARABIC_S_LO && c <= ARABIC_S_HI) ||
                 (c >= ARABIC_A_LO && c <= ARABIC_A_HI) ||
                 (c >= ARABIC_B_LO && c <= ARABIC_B_HI) ||
                 (c >= HEBREW_LO   && c <= HEBREW_HI)   ||
                 (c >= HEBREW_P_LO && c <= HEBREW_P_HI);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8d_core.sv
// Decoder core: sequence state registers and the per-byte decode step.
`default_nettype none

module utf8d_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        data_byte,
    output logic                   res_valid,
    output utf8d_pkg::result_t     res
);
    import utf8d_pkg::*;

    logic [15:0] partial_reg, partial_next;
    logic [1:0]  expected_reg, expected_next;
    logic [1:0]  length_reg, length_next;
    logic [1:0]  skip_reg, skip_next;
    logic [1:0]  seen_reg, seen_next;

    logic        emit;
    logic [15:0] code;
    logic [1:0]  count;
    status_t     stat;
    logic [2:0]  used;

    always_comb
    begin
        partial_next  = partial_reg;
        expected_next = expected_reg;
        length_next   = length_reg;
        skip_next     = skip_reg;
        seen_next     = seen_reg;
        emit          = 1'b0;
        code          = 16'h0000;
        count         = 2'd0;
        stat          = ST_OK;
        used          = {1'b0, seen_reg} + 3'd1;

        priority if (data_byte == 8'h00)
        begin
            // end of string clears everything, even while skipping
            emit          = 1'b1;
            count         = (expected_reg != 2'd0) ? length_reg : 2'd0;
            stat          = ST_END;
            partial_next  = 16'h0000;
            expected_next = 2'd0;
            length_next   = 2'd0;
            skip_next     = 2'd0;
            seen_next     = 2'd0;
        end
        else if (skip_reg != 2'd0)
        begin
            skip_next = skip_reg - 2'd1;
        end
        else if (expected_reg == 2'd0)
        begin
            priority if (data_byte[7] == 1'b0)
            begin
                emit  = 1'b1;
                code  = {8'h00, data_byte};
                count = 2'd1;
            end
            else if (data_byte[7:6] == 2'b10 || data_byte[7:4] == 4'hF)
            begin
                emit = 1'b1;
                stat = ST_INVALID;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                partial_next  = {5'b00000, data_byte[4:0], 6'b000000};
                expected_next = 2'd1;
                length_next   = 2'd2;
                seen_next     = 2'd1;
            end
            else
            begin
                partial_next  = {data_byte[3:0], 12'h000};
                expected_next = 2'd2;
                length_next   = 2'd3;
                seen_next     = 2'd1;
            end
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            if (expected_reg == 2'd1)
            begin
                emit          = 1'b1;
                code          = partial_reg | {10'h000, data_byte[5:0]};
                count         = length_reg;
                partial_next  = 16'h0000;
                expected_next = 2'd0;
                length_next   = 2'd0;
                seen_next     = 2'd0;
            end
            else
            begin
                partial_next  = partial_reg | {4'h0, data_byte[5:0], 6'b000000};
                expected_next = 2'd1;
                seen_next     = seen_reg + 2'd1;
            end
        end
        else
        begin
            // malformed: drop what is left of the declared length
            emit          = 1'b1;
            code          = partial_reg;
            count         = length_reg;
            stat          = ST_MALFORMED;
            skip_next     = ({1'b0, length_reg} > used) ?
                            2'({1'b0, length_reg} - used) : 2'd0;
            partial_next  = 16'h0000;
            expected_next = 2'd0;
            length_next   = 2'd0;
            seen_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= 16'h0000;
            expected_reg <= 2'd0;
            length_reg   <= 2'd0;
            skip_reg     <= 2'd0;
            seen_reg     <= 2'd0;
        end
        else if (byte_accept)
        begin
            partial_reg  <= partial_next;
            expected_reg <= expected_next;
            length_reg   <= length_next;
            skip_reg     <= skip_next;
            seen_reg     <= seen_next;
        end
    end

    assign res_valid         = byte_accept & emit;
    assign res.code_point    = code;
    assign res.byte_count    = count;
    assign res.status        = stat;
    assign res.right_to_left = is_rtl(code);

endmodule

`default_nettype wire

FILE: rtl/core/utf8d_outbuf.sv
// Output register with one skid entry; full holds off new bytes.
`default_nettype none

module utf8d_outbuf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire utf8d_pkg::result_t res,
    output logic                    out_valid,
    output utf8d_pkg::result_t      out_res,
    input  wire logic               out_stall,
    output logic                    full
);
    import utf8d_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign full      = skid_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/utf8_decoder_with_rtl_flag.sv
// Top level: UTF-8 (BMP) byte decoder with right-to-left range flag.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-------------------------------------
//   input   | byte_valid   | byte_stall   | data_byte
//   result  | result_valid | result_stall | code_point byte_count status
//           |              |              | right_to_left
//
// One byte per clock while byte_stall is low. A byte is decoded in the cycle
// it is taken; its result, if any, goes to the result register or skid entry.
// Sequence state lives in the core; a result register plus one skid entry
// sit in front of the result port, so byte_stall rises only when both hold
// an item (it comes from a flop, no path from result_stall).
// Reset (rst_n, async, active low) clears sequence state and both buffers.
// A lead byte, a mid-sequence continuation byte or a skipped byte gives no
// result item.
`default_nettype none

module utf8_decoder_with_rtl_flag (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      code_point,
    output logic [1:0]       byte_count,
    output logic [1:0]       status,
    output logic             right_to_left
);
    import utf8d_pkg::*;

    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    buf_full;

    // skid entry in use means the next result would have nowhere to go
    assign byte_stall  = buf_full;
    assign byte_accept = byte_valid & ~buf_full;

    utf8d_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (data_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    utf8d_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (result_valid),
        .out_res   (out_res),
        .out_stall (result_stall),
        .full      (buf_full)
    );

    assign code_point    = out_res.code_point;
    assign byte_count    = out_res.byte_count;
    assign status        = out_res.status;
    assign right_to_left = out_res.right_to_left;

endmodule

`default_nettype wire

FILE: rtl/core/utf8d_check.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`default_nettype none
`include "utf8_decoder_with_rtl_flag_macros.svh"

module utf8d_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic [15:0] code_point,
    input  wire logic [1:0]  byte_count,
    input  wire logic [1:0]  status,
    input  wire logic        right_to_left
);
    import utf8d_pkg::*;

    // a stalled result stays put
    `UTF8D_ASSERT(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(code_point) && $stable(status)), "stalled result changed")

    // a zero code never lies in a right-to-left range
    `UTF8D_ASSERT_RES(a_rtl_zero, code_point == 16'h0000, !right_to_left, "rtl flag on zero code")

    // end of string always reports a zero code
    `UTF8D_ASSERT_RES(a_end_zero, status == ST_END, code_point == 16'h0000, "end with nonzero code")

    // invalid start carries neither code nor length
    `UTF8D_ASSERT_RES(a_inv, status == ST_INVALID, (code_point == 16'h0000 && byte_count == 2'd0), "invalid start with payload")

endmodule

bind utf8_decoder_with_rtl_flag utf8d_check u_check (.*);

`default_nettype wire
